[rtl/sfr_pkg.sv]
// ---------------------------------------------------------------------------
// sfr_pkg: shared definitions for the serial frame receiver
// Command and event codes, frame position codes and sizing defaults.
// ---------------------------------------------------------------------------
package sfr_pkg;

  // default payload store depth in bytes
  localparam int unsigned MAX_PAYLOAD_DEF = 32;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned SUM_W   = 16;

  // width for position / length compares (length + 2 fits here)
  localparam int unsigned CMP_W = 9;

  // header bytes counted in the length field
  localparam int unsigned HDR_LEN = 4;

  // commands
  localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK  = 2'd2;

  // frame events
  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_ACCEPT = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DROP   = 2'd2;

  // byte positions within a frame
  localparam int unsigned POS_IDLE    = 0;
  localparam int unsigned POS_LEN     = 1;
  localparam int unsigned POS_CODE    = 2;
  localparam int unsigned POS_ADDR_HI = 3;
  localparam int unsigned POS_ADDR_LO = 4;
  localparam int unsigned POS_DATA    = 5;

endpackage

[rtl/sfr_ram.sv]
// ---------------------------------------------------------------------------
// sfr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while the
// read enable is low.
// ---------------------------------------------------------------------------
module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/serial_frame_receiver_top.sv]
// ---------------------------------------------------------------------------
// serial_frame_receiver_top: start-byte framed packet receiver
// Parses start / length / code / address / payload / 16-bit sum frames one
// byte per word, holds a checked frame and serves payload reads by index.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command word: a received
//   byte, a payload read by index, or an acknowledge that releases a held
//   frame. Every input word produces exactly one result word on the output
//   channel (out_valid / out_stall) showing the state after that word.
//   The result of an accepted word is registered and presented from the
//   next cycle on. Throughput is one word per cycle while the output is
//   not stalled; the payload bytes live in a RAM whose registered read
//   port supplies read_value in the result cycle, so a write and a later
//   read never collide.
//   While the output word is stalled it holds, and in_stall is raised only
//   when the output register is full and stalled.
//   cfg_we / cfg_wdata write the start marker (reset value 2); write it only
//   while the block is idle.
//   Synchronous reset clears the parser to waiting-for-start, clears header
//   and sum registers, drops any held frame and empties the output register.
//   The payload RAM is not cleared; only bytes of a held frame are readable.
// ---------------------------------------------------------------------------
module serial_frame_receiver_top
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [BYTE_W-1:0]  cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [BYTE_W-1:0]  in_rx_byte,
  input  logic [INDEX_W-1:0] in_read_index,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_ready,
  output logic [BYTE_W-1:0]  out_frame_code,
  output logic [ADDR_W-1:0]  out_frame_address,
  output logic [COUNT_W-1:0] out_payload_count,
  output logic [BYTE_W-1:0]  out_read_value,
  output logic [EVENT_W-1:0] out_frame_event
);

  localparam int unsigned AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 7);
  localparam int unsigned MAX_LEN = MAX_PAYLOAD + HDR_LEN;

  // parser state
  logic [BYTE_W-1:0] marker_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] code_r, code_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0] sum_hi_r, sum_hi_nxt;
  logic              ready_r, ready_nxt;
  logic [EVENT_W-1:0] ev;

  // output register
  logic               out_valid_r;
  logic               rd_en_r;
  logic               ready_o_r;
  logic [BYTE_W-1:0]  code_o_r;
  logic [ADDR_W-1:0]  addr_o_r;
  logic [COUNT_W-1:0] count_o_r;
  logic [EVENT_W-1:0] ev_o_r;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  logic              advance;
  logic              accept;
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  len_w;
  logic [BYTE_W-1:0] count_nxt;
  logic              rd_hit;

  // handshake: output register empties or drains this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  assign pos_w = CMP_W'(pos_r);
  assign len_w = CMP_W'(len_r);

  // frame parser next state
  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    code_nxt   = code_r;
    addr_nxt   = addr_r;
    sum_nxt    = sum_r;
    sum_hi_nxt = sum_hi_r;
    ready_nxt  = ready_r;
    ev         = EV_NONE;
    ram_we     = 1'b0;
    ram_waddr  = AW'(pos_r - POS_W'(POS_DATA));
    if (in_command == CMD_BYTE) begin
      if (pos_r == POS_W'(POS_IDLE)) begin
        // start marker is ignored while a frame is held
        if (in_rx_byte == marker_r && !ready_r) begin
          sum_nxt = '0;
          pos_nxt = POS_W'(POS_LEN);
        end
      end else if (pos_r == POS_W'(POS_LEN)) begin
        if (CMP_W'(in_rx_byte) > CMP_W'(MAX_LEN)) begin
          pos_nxt = POS_W'(POS_IDLE);
          ev      = EV_DROP;
        end else begin
          sum_nxt = sum_r + SUM_W'(in_rx_byte);
          len_nxt = in_rx_byte;
          pos_nxt = POS_W'(POS_CODE);
        end
      end else if (pos_r == POS_W'(POS_CODE)) begin
        sum_nxt  = sum_r + SUM_W'(in_rx_byte);
        code_nxt = in_rx_byte;
        pos_nxt  = POS_W'(POS_ADDR_HI);
      end else if (pos_r == POS_W'(POS_ADDR_HI)) begin
        sum_nxt  = sum_r + SUM_W'(in_rx_byte);
        addr_nxt = {in_rx_byte, {BYTE_W{1'b0}}};
        pos_nxt  = POS_W'(POS_ADDR_LO);
      end else if (pos_r == POS_W'(POS_ADDR_LO)) begin
        sum_nxt  = sum_r + SUM_W'(in_rx_byte);
        addr_nxt = {addr_r[ADDR_W-1:BYTE_W], in_rx_byte};
        pos_nxt  = POS_W'(POS_DATA);
      end else if (len_r < BYTE_W'(HDR_LEN)) begin
        // short length found at the first byte past the header
        pos_nxt = POS_W'(POS_IDLE);
        ev      = EV_DROP;
      end else if (pos_w <= len_w) begin
        // payload byte; length was bounded so the index stays in the store
        sum_nxt = sum_r + SUM_W'(in_rx_byte);
        ram_we  = 1'b1;
        pos_nxt = pos_r + POS_W'(1);
      end else if (pos_w == len_w + CMP_W'(1)) begin
        sum_hi_nxt = in_rx_byte;
        pos_nxt    = pos_r + POS_W'(1);
      end else if (pos_w == len_w + CMP_W'(2)) begin
        if ({sum_hi_r, in_rx_byte} == sum_r) begin
          ready_nxt = 1'b1;
          ev        = EV_ACCEPT;
        end else begin
          ev = EV_DROP;
        end
        pos_nxt = POS_W'(POS_IDLE);
      end else begin
        pos_nxt = POS_W'(POS_IDLE);
        ev      = EV_DROP;
      end
    end else if (in_command == CMD_ACK) begin
      ready_nxt = 1'b0;
    end
  end

  // payload count after this word; stored length never exceeds MAX_LEN
  assign count_nxt = (ready_nxt && len_nxt >= BYTE_W'(HDR_LEN)) ?
                     len_nxt - BYTE_W'(HDR_LEN) : '0;

  // read hits a byte of the held frame
  assign rd_hit = (in_command == CMD_READ) &&
                  (BYTE_W'(in_read_index) < count_nxt);
  assign ram_re = accept && rd_hit;

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= 8'd2;
      pos_r    <= POS_W'(POS_IDLE);
      len_r    <= '0;
      code_r   <= '0;
      addr_r   <= '0;
      sum_r    <= '0;
      sum_hi_r <= '0;
      ready_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        marker_r <= cfg_wdata;
      end
      if (accept) begin
        pos_r    <= pos_nxt;
        len_r    <= len_nxt;
        code_r   <= code_nxt;
        addr_r   <= addr_nxt;
        sum_r    <= sum_nxt;
        sum_hi_r <= sum_hi_nxt;
        ready_r  <= ready_nxt;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_en_r   <= rd_hit;
      ready_o_r <= ready_nxt;
      code_o_r  <= code_nxt;
      addr_o_r  <= addr_nxt;
      count_o_r <= count_nxt[COUNT_W-1:0];
      ev_o_r    <= ev;
    end
  end

  // payload store
  sfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_payload_ram (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (AW'(in_read_index)),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_frame_ready   = ready_o_r;
  assign out_frame_code    = code_o_r;
  assign out_frame_address = addr_o_r;
  assign out_payload_count = count_o_r;
  assign out_frame_event   = ev_o_r;
  assign out_read_value    = rd_en_r ? ram_rdata : '0;

  // checks
  a_accept_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_event == EV_ACCEPT |-> out_frame_ready)
    else $error("accepted frame not flagged ready");

  a_count_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_count != '0 |-> out_frame_ready)
    else $error("payload count without a held frame");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(pos_r) <= CMP_W'(MAX_PAYLOAD + 6))
    else $error("frame position out of range");

  a_start_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ready_r && pos_r == POS_W'(POS_IDLE) |=> pos_r == POS_W'(POS_IDLE))
    else $error("frame started while a frame is held");

endmodule
